@@ rtl/core/lu2_pkg.sv @@
package lu2_pkg;

  localparam int MAX_CHAN_DEF = 256;
  localparam int MAX_POS_DEF  = 4096;
  localparam int SAMPLE_W_DEF = 16;

  // configuration port
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 17;
  localparam int CHAN_CFG_W  = 9;
  localparam int WIDTH_CFG_W = 13;
  localparam int BATCH_CFG_W = 17;
  localparam int MAX_ROWS    = 65536;

  localparam logic [CFG_IDX_W-1:0] REG_CHAN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BATCH = 2'd2;

  // result fields of fixed width
  localparam int ROW_W   = 16;
  localparam int OPOS_W  = 13;
  localparam int OCHAN_W = 8;

  typedef struct packed {
    logic has_pair;   // position p >= 1: pair of p-1 is due
    logic has_prev2;  // position p >= 2: left neighbor of p-1 is in the older line
    logic last_pos;   // last position of the row: own pair is due as well
    logic frame_end;  // last channel, last position, last row
  } item_flags_t;

  typedef struct packed {
    logic [OPOS_W-1:0]  pos;
    logic [OCHAN_W-1:0] chan;
    logic               last;
    logic               frame_end;
  } res_tag_t;

  function automatic int idx_w(int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

@@ rtl/core/lu2_ram.sv @@
module lu2_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [lu2_pkg::idx_w(DEPTH)-1:0]    waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic                                re,
  input  logic [lu2_pkg::idx_w(DEPTH)-1:0]    raddr,
  output logic [WIDTH-1:0]                    rdata_r
);
  import lu2_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read at the address being written returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/lu2_idx.sv @@
module lu2_idx #(
  parameter int MAX_CHAN      = lu2_pkg::MAX_CHAN_DEF,
  parameter int MAX_POSITIONS = lu2_pkg::MAX_POS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [lu2_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lu2_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                  in_fire,
  output logic [lu2_pkg::idx_w(MAX_CHAN)-1:0]   chan,
  output logic [lu2_pkg::idx_w(MAX_POSITIONS)-1:0] pos,
  output lu2_pkg::item_flags_t                  flags
);
  import lu2_pkg::*;

  localparam int CHW = idx_w(MAX_CHAN);
  localparam int PW  = idx_w(MAX_POSITIONS);
  localparam int CCW = $clog2(MAX_CHAN + 1);
  localparam int IWW = $clog2(MAX_POSITIONS + 1);
  localparam int BW  = $clog2(MAX_ROWS + 1);

  logic [CCW-1:0]   chan_cnt_r, chan_cnt_nxt;
  logic [IWW-1:0]   iw_r, iw_nxt;
  logic [BW-1:0]    batch_r, batch_nxt;
  logic [CHW-1:0]   chan_r, chan_nxt;
  logic [PW-1:0]    pos_r, pos_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  logic [CCW:0]     chan_p1;
  logic [IWW:0]     pos_p1;
  logic [BW-1:0]    row_p1;
  logic             last_ch, last_pos, last_row;

  function automatic logic [31:0] clamp_cfg(logic [31:0] v, logic [31:0] hi);
    logic [31:0] r;
    if (v == 32'd0) begin
      r = 32'd1;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  always_comb begin
    chan_p1  = (CCW+1)'(chan_r) + (CCW+1)'(1);
    pos_p1   = (IWW+1)'(pos_r) + (IWW+1)'(1);
    row_p1   = BW'(row_r) + BW'(1);
    last_ch  = chan_p1 >= {1'b0, chan_cnt_r};
    last_pos = pos_p1 >= {1'b0, iw_r};
    last_row = row_p1 >= batch_r;
  end

  always_comb begin
    chan_cnt_nxt = chan_cnt_r;
    iw_nxt       = iw_r;
    batch_nxt    = batch_r;
    chan_nxt     = chan_r;
    pos_nxt      = pos_r;
    row_nxt      = row_r;
    priority if (cfg_we && (cfg_index == REG_CHAN || cfg_index == REG_WIDTH ||
                            cfg_index == REG_BATCH)) begin
      unique case (cfg_index)
        REG_CHAN: chan_cnt_nxt = CCW'(clamp_cfg(32'(cfg_wdata[CHAN_CFG_W-1:0]),
                                                32'(MAX_CHAN)));
        REG_WIDTH: iw_nxt = IWW'(clamp_cfg(32'(cfg_wdata[WIDTH_CFG_W-1:0]),
                                           32'(MAX_POSITIONS)));
        default: batch_nxt = BW'(clamp_cfg(32'(cfg_wdata[BATCH_CFG_W-1:0]),
                                           32'(MAX_ROWS)));
      endcase
      // any register write restarts the frame
      chan_nxt = '0;
      pos_nxt  = '0;
      row_nxt  = '0;
    end else if (in_fire) begin
      if (!last_ch) begin
        chan_nxt = CHW'(chan_p1);
      end else begin
        chan_nxt = '0;
        if (!last_pos) begin
          pos_nxt = PW'(pos_p1);
        end else begin
          pos_nxt = '0;
          row_nxt = last_row ? '0 : ROW_W'(row_p1);
        end
      end
    end else begin
      // hold the counters
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_cnt_r <= CCW'(1);
      iw_r       <= IWW'(1);
      batch_r    <= BW'(1);
      chan_r     <= '0;
      pos_r      <= '0;
      row_r      <= '0;
    end else begin
      chan_cnt_r <= chan_cnt_nxt;
      iw_r       <= iw_nxt;
      batch_r    <= batch_nxt;
      chan_r     <= chan_nxt;
      pos_r      <= pos_nxt;
      row_r      <= row_nxt;
    end
  end

  assign chan            = chan_r;
  assign pos             = pos_r;
  assign flags.has_pair  = pos_r != '0;
  assign flags.has_prev2 = pos_r > PW'(1);
  assign flags.last_pos  = last_pos;
  assign flags.frame_end = last_pos & last_ch & last_row;

  a_chan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    CCW'(chan_r) < chan_cnt_r)
    else $error("channel counter reached the channel count");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    IWW'(pos_r) < iw_r)
    else $error("position counter reached the row width");

endmodule

@@ rtl/core/lu2_emit.sv @@
module lu2_emit #(
  parameter int SAMPLE_WIDTH  = lu2_pkg::SAMPLE_W_DEF,
  parameter int MAX_CHAN      = lu2_pkg::MAX_CHAN_DEF,
  parameter int MAX_POSITIONS = lu2_pkg::MAX_POS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_fire,
  input  logic [SAMPLE_WIDTH-1:0]                  sample,
  input  logic [lu2_pkg::idx_w(MAX_CHAN)-1:0]      k_in,
  input  logic [lu2_pkg::idx_w(MAX_POSITIONS)-1:0] p_in,
  input  lu2_pkg::item_flags_t                     flags_in,
  input  logic [SAMPLE_WIDTH-1:0]                  nl_rdata,
  input  logic [SAMPLE_WIDTH-1:0]                  ol_rdata,
  output logic                                     ram_we,
  output logic [lu2_pkg::idx_w(MAX_CHAN)-1:0]      ram_waddr,
  output logic [SAMPLE_WIDTH-1:0]                  nl_wdata,
  output logic [SAMPLE_WIDTH-1:0]                  ol_wdata,
  input  logic                                     space,
  output logic                                     push,
  output lu2_pkg::res_tag_t                        res_tag,
  output logic [SAMPLE_WIDTH-1:0]                  res_value,
  output logic                                     ready
);
  import lu2_pkg::*;

  localparam int CHW = idx_w(MAX_CHAN);
  localparam int PW  = idx_w(MAX_POSITIONS);
  localparam int NW  = SAMPLE_WIDTH + 2;
  // floor(n/3) = (n * ceil(2^(NW+1)/3)) >> (NW+1) for any NW-bit n
  localparam logic [NW+1:0] POW   = {1'b1, {(NW+1){1'b0}}};
  localparam logic [NW-1:0] RECIP = NW'((POW + (NW+2)'(2)) / (NW+2)'(3));
  localparam logic [SAMPLE_WIDTH-1:0] SIGN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // result slots in emission order; bit 1 selects the current position
  localparam logic [1:0] SLOT_PREV_LO = 2'd0;
  localparam logic [1:0] SLOT_PREV_HI = 2'd1;
  localparam logic [1:0] SLOT_CUR_LO  = 2'd2;
  localparam logic [1:0] SLOT_CUR_HI  = 2'd3;

  logic                    s_valid_r;
  logic [SAMPLE_WIDTH-1:0] x_r;
  logic [CHW-1:0]          k_r;
  logic [PW-1:0]           p_r;
  item_flags_t             fl_r;
  logic [1:0]              slot_r;
  logic                    fwd_r;
  logic [SAMPLE_WIDTH-1:0] fwd_new_r, fwd_old_r;

  logic [SAMPLE_WIDTH-1:0] c, o, l, lp, side, centre;
  logic [1:0]              last_slot;
  logic                    no_result, done, is_last;
  logic [NW-1:0]           num;
  logic [2*NW-1:0]         prod;
  logic [SAMPLE_WIDTH-1:0] q;
  logic [PW-1:0]           base;

  always_comb begin
    // the word written back in the previous cycle has not reached the read port
    c  = fwd_r ? fwd_new_r : nl_rdata;
    o  = fwd_r ? fwd_old_r : ol_rdata;
    l  = fl_r.has_prev2 ? o : c;
    lp = fl_r.has_pair ? c : x_r;

    last_slot = fl_r.last_pos ? SLOT_CUR_HI : SLOT_PREV_HI;
    no_result = !fl_r.has_pair && !fl_r.last_pos;
    is_last   = slot_r == last_slot;
    push      = s_valid_r && !no_result && space;
    done      = s_valid_r && (no_result || (space && is_last));
    ready     = !s_valid_r || done;

    unique case (slot_r)
      SLOT_PREV_LO: begin side = l;  centre = c;   end
      SLOT_PREV_HI: begin side = x_r; centre = c;  end
      SLOT_CUR_LO:  begin side = lp; centre = x_r; end
      default:      begin side = x_r; centre = x_r; end
    endcase

    // offset binary keeps the sum non-negative: n = a + 2b + 1 + 3*2^(W-1)
    num  = NW'(side ^ SIGN) + (NW'(centre ^ SIGN) << 1) + NW'(1);
    prod = (2*NW)'(num) * (2*NW)'(RECIP);
    q    = prod[NW+1 +: SAMPLE_WIDTH];

    base = slot_r[1] ? p_r : p_r - PW'(1);
  end

  assign res_value         = q ^ SIGN;
  assign res_tag.pos       = OPOS_W'({base, slot_r[0]});
  assign res_tag.chan      = OCHAN_W'(k_r);
  assign res_tag.last      = is_last;
  assign res_tag.frame_end = is_last && fl_r.frame_end;

  assign ram_we    = done;
  assign ram_waddr = k_r;
  assign nl_wdata  = x_r;
  assign ol_wdata  = c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_fire) begin
      s_valid_r <= 1'b1;
    end else if (done) begin
      s_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_r       <= sample;
      k_r       <= k_in;
      p_r       <= p_in;
      fl_r      <= flags_in;
      slot_r    <= flags_in.has_pair ? SLOT_PREV_LO : SLOT_CUR_LO;
      fwd_r     <= done && (k_r == k_in);
      fwd_new_r <= x_r;
      fwd_old_r <= c;
    end else if (push) begin
      slot_r <= slot_r + 2'd1;
    end
  end

  a_slot_advance: assert property (@(posedge clk) disable iff (!rst_n)
    push && !is_last |=> s_valid_r && (slot_r == $past(slot_r) + 2'd1))
    else $error("result slot did not advance after a partial push");

  a_end_on_own_pair: assert property (@(posedge clk) disable iff (!rst_n)
    push && res_tag.frame_end |-> slot_r == SLOT_CUR_HI)
    else $error("frame end flagged outside the last position's final result");

endmodule

@@ rtl/core/lu2_obuf.sv @@
module lu2_obuf #(
  parameter int SAMPLE_WIDTH = lu2_pkg::SAMPLE_W_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  lu2_pkg::res_tag_t        tag_in,
  input  logic [SAMPLE_WIDTH-1:0]  value_in,
  output logic                     space,
  output logic                     out_valid,
  input  logic                     out_ready,
  output lu2_pkg::res_tag_t        tag_out,
  output logic [SAMPLE_WIDTH-1:0]  value_out
);
  import lu2_pkg::*;

  res_tag_t                tag_q [2];
  logic [SAMPLE_WIDTH-1:0] val_q [2];
  logic                    wp_r, rp_r;
  logic [1:0]              cnt_r, cnt_nxt;
  logic                    pop;

  // space comes from the count register alone, so ready never depends on out_ready
  assign space     = cnt_r != 2'd2;
  assign out_valid = cnt_r != 2'd0;
  assign pop       = out_valid && out_ready;
  assign tag_out   = tag_q[rp_r];
  assign value_out = val_q[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      tag_q[wp_r] <= tag_in;
      val_q[wp_r] <= value_in;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> cnt_r != 2'd2)
    else $error("word pushed into a full output buffer");

  a_ptr_match_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) == (wp_r == rp_r))
    else $error("output buffer pointers disagree with the count");

endmodule

@@ rtl/core/linear_upsample_x2_1d.sv @@
// An accepted sample is registered in the result stage; each result it gives is registered in the
// output buffer before it shows on out_*. An item gives n = 0, 2 or 4 results and holds the result
// stage until its last one is pushed; the single result port takes one word per cycle while the
// output buffer has space. Line stores are synchronous RAMs with a registered read and a
// same-address bypass for back-to-back items. Reset: counters clear, registers return to 1, output
// buffer empties; line stores are not cleared and need no clearing pass.
module linear_upsample_x2_1d #(
  parameter int MAX_CHAN      = lu2_pkg::MAX_CHAN_DEF,
  parameter int MAX_POSITIONS = lu2_pkg::MAX_POS_DEF,
  parameter int SAMPLE_WIDTH  = lu2_pkg::SAMPLE_W_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [lu2_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lu2_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]     in_sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [lu2_pkg::OPOS_W-1:0]         out_position,
  output logic [lu2_pkg::OCHAN_W-1:0]        out_channel,
  output logic signed [SAMPLE_WIDTH-1:0]     out_value,
  output logic                               out_last,
  output logic                               out_frame_end
);
  import lu2_pkg::*;

  localparam int CHW = idx_w(MAX_CHAN);
  localparam int PW  = idx_w(MAX_POSITIONS);

  logic                    in_fire;
  logic [CHW-1:0]          chan;
  logic [PW-1:0]           pos;
  item_flags_t             flags;
  logic [SAMPLE_WIDTH-1:0] nl_rdata, ol_rdata, nl_wdata, ol_wdata;
  logic                    ram_we;
  logic [CHW-1:0]          ram_waddr;
  logic                    space, push;
  res_tag_t                res_tag, tag_out;
  logic [SAMPLE_WIDTH-1:0] res_value, value_out;

  assign in_fire = in_valid && in_ready;

  lu2_idx #(
    .MAX_CHAN      (MAX_CHAN),
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_idx (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .chan      (chan),
    .pos       (pos),
    .flags     (flags)
  );

  lu2_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (MAX_CHAN)
  ) u_newer_line (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (nl_wdata),
    .re      (in_fire),
    .raddr   (chan),
    .rdata_r (nl_rdata)
  );

  lu2_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (MAX_CHAN)
  ) u_older_line (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ol_wdata),
    .re      (in_fire),
    .raddr   (chan),
    .rdata_r (ol_rdata)
  );

  lu2_emit #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .MAX_CHAN      (MAX_CHAN),
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .sample    (in_sample),
    .k_in      (chan),
    .p_in      (pos),
    .flags_in  (flags),
    .nl_rdata  (nl_rdata),
    .ol_rdata  (ol_rdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .nl_wdata  (nl_wdata),
    .ol_wdata  (ol_wdata),
    .space     (space),
    .push      (push),
    .res_tag   (res_tag),
    .res_value (res_value),
    .ready     (in_ready)
  );

  lu2_obuf #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .tag_in    (res_tag),
    .value_in  (res_value),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .tag_out   (tag_out),
    .value_out (value_out)
  );

  assign out_position  = tag_out.pos;
  assign out_channel   = tag_out.chan;
  assign out_value     = value_out;
  assign out_last      = tag_out.last;
  assign out_frame_end = tag_out.frame_end;

endmodule
